// ----- src/dmgt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmgt_pkg
// Types and constants shared by the dual mute gate/trigger block.
// ----------------------------------------------------------------------------
package dmgt_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MODE_BITS      = 3'd0,
      CSR_PATCH_MASK     = 3'd1,
      CSR_GATE_THRESHOLD = 3'd2,
      CSR_TRIG_LOW       = 3'd3,
      CSR_TRIG_HIGH      = 3'd4,
      CSR_MUTE_LEVEL     = 3'd5,
      CSR_CLIP_LOW       = 3'd6,
      CSR_CLIP_HIGH      = 3'd7
   } csr_index_type;

   // mode_bits fields
   localparam int unsigned ModeBothGate = 0;
   localparam int unsigned ModeAGate    = 1;
   localparam int unsigned ModeBGate    = 2;
   localparam int unsigned ModeLowGate  = 3;

   // patch_mask fields
   localparam int unsigned PatchBothCtl = 0;
   localparam int unsigned PatchACtl    = 1;
   localparam int unsigned PatchBCtl    = 2;
   localparam int unsigned PatchASig    = 3;
   localparam int unsigned PatchBSig    = 4;
   localparam int unsigned PatchAOut    = 5;
   localparam int unsigned PatchBOut    = 6;

   // manual_mute fields
   localparam int unsigned BtnBoth = 0;
   localparam int unsigned BtnA    = 1;
   localparam int unsigned BtnB    = 2;

   // register reset values
   localparam logic        [3:0]  ModeBitsReset      = 4'd7;
   localparam logic        [6:0]  PatchMaskReset     = 7'd0;
   localparam logic signed [15:0] GateThresholdReset = 16'sd1024;
   localparam logic signed [15:0] TrigLowReset       = 16'sd102;
   localparam logic signed [15:0] TrigHighReset      = 16'sd1024;
   localparam logic signed [15:0] MuteLevelReset     = 16'sd0;
   localparam logic signed [15:0] ClipLowReset       = -16'sd10240;
   localparam logic signed [15:0] ClipHighReset      = 16'sd10240;

   typedef struct packed {
      logic signed [15:0] both_control;
      logic signed [15:0] a_control;
      logic signed [15:0] b_control;
      logic        [2:0]  manual_mute;
      logic signed [15:0] a_sample;
      logic signed [15:0] b_sample;
   } req_type;

   typedef struct packed {
      logic signed [15:0] a_out;
      logic signed [15:0] b_out;
      logic               a_muted;
      logic               b_muted;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/dual_mute_gate_trigger_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_mute_gate_trigger_top
// Pipeline: a request passes the input register, then the result register, before
// rsp_valid rises; rsp_stall can hold it in either stage. Throughput is one request
// per cycle while rsp_stall is low, set by the single compare/mux pass between the
// two registers and the kept mute flags. Synchronous reset loads register defaults,
// clears the kept mute flags, arms the Schmitt levels high and empties both stages.
// ----------------------------------------------------------------------------
module dual_mute_gate_trigger_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  dmgt_pkg::req_type               req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output dmgt_pkg::rsp_type                     rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [dmgt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire  [dmgt_pkg::CsrDataWidth-1:0]     csr_data
);
   import dmgt_pkg::*;

   typedef struct packed {
      logic level;
      logic fire;
   } schmitt_type;

   // configuration registers
   logic        [3:0]  mode_ff;
   logic        [6:0]  patch_ff;
   logic signed [15:0] gate_thr_ff;
   logic signed [15:0] trig_low_ff;
   logic signed [15:0] trig_high_ff;
   logic signed [15:0] mute_level_ff;
   logic signed [15:0] clip_low_ff;
   logic signed [15:0] clip_high_ff;

   // pipeline
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // kept detector state: 0 both, 1 A, 2 B
   logic [2:0] tog_ff, tog_in;
   logic [2:0] lvl_ff, lvl_in;

   logic              out_free, move, accept;
   logic [2:0]        clr, adv, ctl_mute, tog_eff, lvl_eff;
   logic signed [15:0] ctl [3];
   schmitt_type       sch [3];
   logic              any_out, both_mute, a_mute, b_mute;
   logic signed [15:0] a_val, b_val;

   function automatic schmitt_type schmitt(input logic level, input logic signed [15:0] v,
                                           input logic signed [15:0] lo,
                                           input logic signed [15:0] hi);
      schmitt_type r;
      r.level = level;
      r.fire  = 1'b0;
      if (level) begin
         if (v <= lo) r.level = 1'b0;
      end else if (v >= hi) begin
         r.level = 1'b1;
         r.fire  = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clip(input logic signed [15:0] v,
                                               input logic signed [15:0] lo,
                                               input logic signed [15:0] hi);
      logic signed [15:0] r;
      r = (v < lo) ? lo : v;
      r = (r > hi) ? hi : r;
      return r;
   endfunction

   // handshake
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ModeBitsReset;
         patch_ff      <= PatchMaskReset;
         gate_thr_ff   <= GateThresholdReset;
         trig_low_ff   <= TrigLowReset;
         trig_high_ff  <= TrigHighReset;
         mute_level_ff <= MuteLevelReset;
         clip_low_ff   <= ClipLowReset;
         clip_high_ff  <= ClipHighReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MODE_BITS:      mode_ff       <= csr_data[3:0];
            CSR_PATCH_MASK:     patch_ff      <= csr_data[6:0];
            CSR_GATE_THRESHOLD: gate_thr_ff   <= csr_data;
            CSR_TRIG_LOW:       trig_low_ff   <= csr_data;
            CSR_TRIG_HIGH:      trig_high_ff  <= csr_data;
            CSR_MUTE_LEVEL:     mute_level_ff <= csr_data;
            CSR_CLIP_LOW:       clip_low_ff   <= csr_data;
            CSR_CLIP_HIGH:      clip_high_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // per-path mute decisions
   assign any_out = patch_ff[PatchAOut] || patch_ff[PatchBOut];
   assign adv     = {patch_ff[PatchBOut], patch_ff[PatchAOut], any_out};
   assign ctl[0]  = in_ff.both_control;
   assign ctl[1]  = in_ff.a_control;
   assign ctl[2]  = in_ff.b_control;

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         // unpatched or gate-mode paths drop their kept state
         clr[p]     = !patch_ff[PatchBothCtl + p] || mode_ff[ModeBothGate + p];
         tog_eff[p] = clr[p] ? 1'b0 : tog_ff[p];
         lvl_eff[p] = clr[p] ? 1'b1 : lvl_ff[p];
         sch[p]     = schmitt(lvl_eff[p], ctl[p], trig_low_ff, trig_high_ff);
         if (adv[p] && !clr[p]) begin
            lvl_in[p] = sch[p].level;
            tog_in[p] = tog_eff[p] ^ sch[p].fire;
         end else begin
            lvl_in[p] = lvl_eff[p];
            tog_in[p] = tog_eff[p];
         end
         if (!patch_ff[PatchBothCtl + p]) begin
            ctl_mute[p] = 1'b0;
         end else if (mode_ff[ModeBothGate + p]) begin
            ctl_mute[p] = mode_ff[ModeLowGate] ? (ctl[p] < gate_thr_ff)
                                               : (ctl[p] >= gate_thr_ff);
         end else begin
            ctl_mute[p] = tog_in[p];
         end
      end
   end

   // section outputs
   always_comb begin
      both_mute = in_ff.manual_mute[BtnBoth] || ctl_mute[0];
      a_mute    = both_mute || in_ff.manual_mute[BtnA] || ctl_mute[1];
      b_mute    = both_mute || in_ff.manual_mute[BtnB] || ctl_mute[2];
      if (a_mute)                 a_val = mute_level_ff;
      else if (patch_ff[PatchASig]) a_val = in_ff.a_sample;
      else                        a_val = '0;
      if (b_mute)                 b_val = mute_level_ff;
      else if (patch_ff[PatchBSig]) b_val = in_ff.b_sample;
      else if (patch_ff[PatchASig]) b_val = in_ff.a_sample;
      else                        b_val = '0;
      rsp_in.a_out   = patch_ff[PatchAOut] ? clip(a_val, clip_low_ff, clip_high_ff) : '0;
      rsp_in.b_out   = patch_ff[PatchBOut] ? clip(b_val, clip_low_ff, clip_high_ff) : '0;
      rsp_in.a_muted = patch_ff[PatchAOut] && a_mute;
      rsp_in.b_muted = patch_ff[PatchBOut] && b_mute;
   end

   // stage valid flags
   always_comb begin
      in_valid_in  = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
      rsp_valid_in = move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tog_ff       <= '0;
         lvl_ff       <= '1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            tog_ff <= tog_in;
            lvl_ff <= lvl_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) in_ff <= req_data;
      if (move)   rsp_ff <= rsp_in;
   end

   // checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input stage");

   a_move_fills_output: assert property (@(posedge clock)
      !reset && move |=> rsp_valid_ff)
      else $error("result lost after stage move");

   a_cleared_both_path: assert property (@(posedge clock)
      !reset && move && clr[0] |=> !tog_ff[0] && lvl_ff[0])
      else $error("both path kept state not cleared");

   a_unpatched_a_zero: assert property (@(posedge clock)
      !reset && move && !patch_ff[PatchAOut] |=> !rsp_ff.a_muted && rsp_ff.a_out == '0)
      else $error("unpatched A output not zero");

endmodule
`default_nettype wire
